>>> rtl/core/wsfr_pkg.sv
// Shared types, constants and the frame classifier of the WebSocket frame receiver.
// Depends on nothing; every other file of the block refers to it by scoped names.
package wsfr_pkg;

	localparam int LEN_BITS = 16;

	localparam logic [LEN_BITS-1:0] MAX_MSG_RESET = 16'd1024;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [2:0] STATUS_TEXT    = 3'd0;
	localparam logic [2:0] STATUS_PING    = 3'd1;
	localparam logic [2:0] STATUS_CLOSE   = 3'd2;
	localparam logic [2:0] STATUS_IGNORED = 3'd3;
	localparam logic [2:0] STATUS_LEN_ERR = 3'd4;

	typedef struct packed {
		logic                byte_valid;
		logic [7:0]          payload_byte;
		logic                frame_done;
		logic [2:0]          frame_status;
		logic [3:0]          frame_opcode;
		logic                frame_fin;
		logic [LEN_BITS-1:0] delivered_len;
	} result_t;

	function automatic logic [2:0] class_of(input logic [3:0] op);
		logic [2:0] cls;
		case (op)
			OP_TEXT:  cls = STATUS_TEXT;
			OP_PING:  cls = STATUS_PING;
			OP_CLOSE: cls = STATUS_CLOSE;
			default:  cls = STATUS_IGNORED;
		endcase
		return cls;
	endfunction

endpackage

>>> rtl/core/wsfr_if.sv
// Channel interfaces of the WebSocket frame receiver: received bytes, results, limit writes.
// Depends on wsfr_pkg for the length width.
interface wsfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_res_if;
	logic                         valid;
	logic                         ready;
	logic                         byte_valid;
	logic [7:0]                   payload_byte;
	logic                         frame_done;
	logic [2:0]                   frame_status;
	logic [3:0]                   frame_opcode;
	logic                         frame_fin;
	logic [wsfr_pkg::LEN_BITS-1:0] delivered_len;

	modport source (output valid, output byte_valid, output payload_byte, output frame_done,
		output frame_status, output frame_opcode, output frame_fin, output delivered_len,
		input ready);
	modport sink (input valid, input byte_valid, input payload_byte, input frame_done,
		input frame_status, input frame_opcode, input frame_fin, input delivered_len,
		output ready);
endinterface

interface wsfr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [wsfr_pkg::LEN_BITS-1:0] max_message_size;

	modport source (output valid, output max_message_size, input ready);
	modport sink (input valid, input max_message_size, output ready);
endinterface

>>> rtl/core/wsfr_parser.sv
// Frame header parser: phase register, held header fields, length and position counters.
// Depends on wsfr_pkg; produces at most one result per accepted byte.
module wsfr_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    rx_byte,
	input  logic [wsfr_pkg::LEN_BITS-1:0] max_size,
	output logic                          res_vld,
	output wsfr_pkg::result_t             res
);

	localparam int LB = wsfr_pkg::LEN_BITS;

	localparam logic [2:0] PH_HDR     = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_EXT_HI  = 3'd2;
	localparam logic [2:0] PH_EXT_LO  = 3'd3;
	localparam logic [2:0] PH_MASK    = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_SKIP    = 3'd6;

	logic [2:0]    phase_q, phase_n;
	logic [3:0]    opcode_q, opcode_n;
	logic          fin_q, fin_n;
	logic          masked_q, masked_n;
	logic [LB-1:0] len_q, len_n;
	logic [LB-1:0] pos_q, pos_n;
	logic [2:0]    skip_q, skip_n;

	logic [2:0]    skip_inc;
	logic [LB:0]   pos_inc;
	logic [6:0]    len7;
	logic          done;
	logic          dv;
	logic [2:0]    status;
	logic [LB-1:0] dl;

	assign skip_inc = skip_q + 3'd1;
	assign pos_inc  = {1'b0, pos_q} + {{LB{1'b0}}, 1'b1};
	assign len7     = rx_byte[6:0];

	always_comb begin
		phase_n  = phase_q;
		opcode_n = opcode_q;
		fin_n    = fin_q;
		masked_n = masked_q;
		len_n    = len_q;
		pos_n    = pos_q;
		skip_n   = skip_q;
		done     = 1'b0;
		dv       = 1'b0;
		status   = wsfr_pkg::class_of(opcode_q);
		unique case (phase_q)
			PH_LEN: begin
				masked_n = rx_byte[7];
				if (len7 == wsfr_pkg::LEN7_EXT64) begin
					skip_n  = 3'd0;
					len_n   = '0;
					phase_n = PH_SKIP;
				end else if (len7 == wsfr_pkg::LEN7_EXT16) begin
					len_n   = '0;
					phase_n = PH_EXT_HI;
				end else begin
					len_n = LB'(len7);
					if (masked_n) begin
						skip_n  = 3'd0;
						phase_n = PH_MASK;
					end else if (len_n == '0) begin
						phase_n = PH_HDR;
						done    = 1'b1;
					end else begin
						pos_n   = '0;
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_EXT_HI: begin
				len_n   = LB'({rx_byte, 8'h00});
				phase_n = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				len_n = len_q | LB'(rx_byte);
				if (masked_q) begin
					skip_n  = 3'd0;
					phase_n = PH_MASK;
				end else if (len_n == '0) begin
					phase_n = PH_HDR;
					done    = 1'b1;
				end else begin
					pos_n   = '0;
					phase_n = PH_PAYLOAD;
				end
			end
			PH_MASK: begin
				if (skip_inc < 3'd4) begin
					skip_n = skip_inc;
				end else begin
					skip_n = 3'd0;
					if (len_q == '0) begin
						phase_n = PH_HDR;
						done    = 1'b1;
					end else begin
						pos_n   = '0;
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				dv    = pos_q < max_size;
				pos_n = pos_inc[LB-1:0];
				if (pos_inc >= {1'b0, len_q}) begin
					phase_n = PH_HDR;
					done    = 1'b1;
				end
			end
			PH_SKIP: begin
				skip_n = skip_inc;
				if (skip_inc == 3'd0) begin
					phase_n = PH_HDR;
					done    = 1'b1;
					status  = wsfr_pkg::STATUS_LEN_ERR;
				end
			end
			default: begin
				fin_n    = rx_byte[7];
				opcode_n = rx_byte[3:0];
				masked_n = 1'b0;
				len_n    = '0;
				pos_n    = '0;
				skip_n   = 3'd0;
				phase_n  = PH_LEN;
			end
		endcase
	end

	assign dl = (len_n < max_size) ? len_n : max_size;

	always_comb begin
		res_vld           = accept && (dv || done);
		res.byte_valid    = dv;
		res.payload_byte  = dv ? rx_byte : 8'h00;
		res.frame_done    = done;
		res.frame_status  = done ? status : 3'd0;
		res.frame_opcode  = done ? opcode_q : 4'h0;
		res.frame_fin     = done && fin_q;
		res.delivered_len = (done && status != wsfr_pkg::STATUS_LEN_ERR) ? dl : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR;
			opcode_q <= 4'h0;
			fin_q    <= 1'b0;
			masked_q <= 1'b0;
			len_q    <= '0;
			pos_q    <= '0;
			skip_q   <= 3'd0;
		end else if (accept) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			fin_q    <= fin_n;
			masked_q <= masked_n;
			len_q    <= len_n;
			pos_q    <= pos_n;
			skip_q   <= skip_n;
		end
	end

endmodule

>>> rtl/core/websocket_frame_receiver.sv
// WebSocket frame receiver top level: limit register, parser and a two-entry result buffer.
// Depends on wsfr_pkg, wsfr_if and wsfr_parser.
// One received byte is taken per cycle while rx.ready is high. Each byte passes the parser's
// phase logic in the cycle it is accepted, and any result is registered in the result register
// or in a skid entry behind it. The skid entry keeps bytes flowing for one extra
// result while the consumer stalls; rx.ready drops only while that entry is full. Mask keys are
// skipped and not applied, 64-bit lengths end in a length error after eight skipped bytes, and
// payload bytes beyond max_message_size are dropped. The limit port is always ready.
module websocket_frame_receiver (
	input  logic              clk,
	input  logic              arst_n,
	wsfr_rx_if.sink           rx,
	wsfr_res_if.source        res,
	wsfr_cfg_if.sink          cfg
);

	logic [wsfr_pkg::LEN_BITS-1:0] max_size_q;
	logic                          accept;
	logic                          new_vld;
	wsfr_pkg::result_t             new_res;
	logic                          out_valid_q;
	wsfr_pkg::result_t             out_q;
	logic                          skid_valid_q;
	wsfr_pkg::result_t             skid_q;
	logic                          out_load;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !skid_valid_q;
	assign accept    = rx.valid && rx.ready;
	assign out_load  = res.ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= wsfr_pkg::MAX_MSG_RESET;
		end else if (cfg.valid) begin
			max_size_q <= cfg.max_message_size;
		end
	end

	wsfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx.rx_byte),
		.max_size (max_size_q),
		.res_vld  (new_vld),
		.res      (new_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || new_vld;
			skid_valid_q <= 1'b0;
		end else if (new_vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : new_res;
		end else if (new_vld) begin
			skid_q <= new_res;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.byte_valid    = out_q.byte_valid;
	assign res.payload_byte  = out_q.payload_byte;
	assign res.frame_done    = out_q.frame_done;
	assign res.frame_status  = out_q.frame_status;
	assign res.frame_opcode  = out_q.frame_opcode;
	assign res.frame_fin     = out_q.frame_fin;
	assign res.delivered_len = out_q.delivered_len;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while result register empty");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.byte_valid || out_q.frame_done))
		else $error("result carries neither a byte nor a frame end");

	a_len_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.frame_done && out_q.frame_status == wsfr_pkg::STATUS_LEN_ERR)
		|-> (out_q.delivered_len == '0 && !out_q.byte_valid))
		else $error("length error reports delivered bytes");

	a_no_loss_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !res.ready) |=> (skid_valid_q && out_valid_q))
		else $error("buffered result dropped during stall");

endmodule
